// ----- rtl/ttce_pkg.sv -----
// Shared types and character constants for the text terminal character engine.
// Depends on nothing; the decoder, command queue, executor and top import it.
`default_nettype none

package ttce_pkg;

  // Character codes recognized by the engine.
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_BEL      = 8'h07;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_VT       = 8'h0B;
  localparam logic [7:0] CH_FF       = 8'h0C;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SO       = 8'h0E;
  localparam logic [7:0] CH_SI       = 8'h0F;
  localparam logic [7:0] CH_SUB      = 8'h1A;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_RS       = 8'h1E;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ROW_MAX  = 8'h37;
  localparam logic [7:0] CH_EQUAL    = 8'h3D;
  localparam logic [7:0] CH_COL_MAX  = 8'h6F;

  // Commands passed from the decoder to the executor.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_READ,
    OP_BELL,
    OP_BS,
    OP_LF,
    OP_VT,
    OP_FF,
    OP_CR,
    OP_CLEAR,
    OP_HOME,
    OP_POS,
    OP_PUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;  // character to store
    logic [4:0] row;   // read row or escape row offset
    logic [6:0] col;   // read column or escape column offset
  } cmd_t;

  // Executor states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_FILL,
    BK_SCROLL,
    BK_DRAIN
  } bk_state_t;

endpackage

`default_nettype wire

// ----- rtl/ttce_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module ttce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1920
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ttce_front.sv -----
// Front end: accepts input words, tracks the ESC '=' row col sequence and
// turns each word into a command. Depends on ttce_pkg.
`default_nettype none

module ttce_front
  import ttce_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic       stall,
  input  wire logic       in_req_type,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic [4:0] in_read_row,
  input  wire logic [6:0] in_read_col,
  output      logic       in_full,
  output      logic       cmd_push,
  output      cmd_t       cmd
);

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_START,
    ESC_EQUAL,
    ESC_ROW
  } esc_t;

  esc_t       esc_r, esc_nxt;
  logic [7:0] esc_row_r, esc_row_nxt;
  logic       accept;
  logic       row_ok;
  logic       col_ok;

  assign in_full  = stall;
  assign accept   = in_push && !stall;
  assign cmd_push = accept;
  assign row_ok   = in_rx_byte inside {[CH_SPACE:CH_ROW_MAX]};
  assign col_ok   = in_rx_byte inside {[CH_SPACE:CH_COL_MAX]};

  // Sequence state.
  always_comb begin
    esc_nxt     = esc_r;
    esc_row_nxt = esc_row_r;
    if (accept && !in_req_type) begin
      case (esc_r)
        ESC_IDLE: begin
          if (in_rx_byte == CH_ESC) begin
            esc_nxt = ESC_START;
          end
        end
        ESC_START: begin
          esc_nxt = (in_rx_byte == CH_EQUAL) ? ESC_EQUAL : ESC_IDLE;
        end
        ESC_EQUAL: begin
          if (row_ok) begin
            esc_nxt     = ESC_ROW;
            esc_row_nxt = in_rx_byte;
          end else begin
            esc_nxt = ESC_IDLE;
          end
        end
        default: begin
          esc_nxt = ESC_IDLE;
        end
      endcase
    end
  end

  // Command decode.
  always_comb begin
    cmd.op   = OP_NOP;
    cmd.data = in_rx_byte;
    cmd.row  = in_read_row;
    cmd.col  = in_read_col;
    if (in_req_type) begin
      cmd.op = OP_READ;
    end else begin
      case (esc_r)
        ESC_IDLE: begin
          case (in_rx_byte)
            CH_NUL, CH_SO, CH_SI, CH_ESC: cmd.op = OP_NOP;
            CH_BEL:  cmd.op = OP_BELL;
            CH_BS:   cmd.op = OP_BS;
            CH_LF:   cmd.op = OP_LF;
            CH_VT:   cmd.op = OP_VT;
            CH_FF:   cmd.op = OP_FF;
            CH_CR:   cmd.op = OP_CR;
            CH_SUB:  cmd.op = OP_CLEAR;
            CH_RS:   cmd.op = OP_HOME;
            default: cmd.op = OP_PUT;
          endcase
        end
        ESC_ROW: begin
          if (col_ok) begin
            cmd.op  = OP_POS;
            cmd.row = 5'(esc_row_r - CH_SPACE);
            cmd.col = 7'(in_rx_byte - CH_SPACE);
          end
        end
        default: begin
          cmd.op = OP_NOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r     <= ESC_IDLE;
      esc_row_r <= 8'h00;
    end else begin
      esc_r     <= esc_nxt;
      esc_row_r <= esc_row_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ttce_cmdq.sv -----
// Two-entry command queue between the decoder and the executor.
// Depends on ttce_pkg.
`default_nettype none

module ttce_cmdq
  import ttce_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t din,
  output      logic full,
  input  wire logic pop,
  output      cmd_t dout,
  output      logic empty
);

  cmd_t       slots_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ttce_back.sv -----
// Executor: owns the cursor and the screen RAM, carries out commands, runs
// the clear and scroll sweeps and holds the result register.
// Depends on ttce_pkg and ttce_ram.
`default_nettype none

module ttce_back
  import ttce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cmd_valid,
  input  wire cmd_t       cmd,
  output      logic       cmd_pop,
  input  wire logic       out_pop,
  output      logic       out_empty,
  output      logic       out_redisplay,
  output      logic       out_bell,
  output      logic [7:0] out_cell_char,
  output      logic [6:0] out_cursor_col,
  output      logic [4:0] out_cursor_row,
  output      logic       init_busy
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int RXW   = (RW > 5) ? RW : 5;

  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_DST  = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] BOT_START = AW'(CELLS - COLUMNS);
  localparam logic [CW-1:0] COL_MAX   = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_MAX   = RW'(ROWS - 1);

  bk_state_t     state_r, state_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;
  logic          wr_pend_r, wr_pend_nxt;
  logic          pend_r, pend_nxt;
  logic          init_r, init_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_redisp_r, out_bell_r;
  logic [7:0]    out_cell_r;
  logic [6:0]    out_col_r;
  logic [4:0]    out_row_r;

  logic          emit, e_redisp, e_bell;
  logic [7:0]    e_cell;
  logic [RXW-1:0] row_ext;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic          take, col_last, row_last, read_ok;
  logic [AW-1:0] cur_addr, req_addr;
  logic [CW-1:0] pos_col;
  logic [RW-1:0] pos_row;

  assign take      = (state_r == BK_IDLE) && cmd_valid && (!out_valid_r || out_pop);
  assign cmd_pop   = take;
  assign col_last  = (cur_col_r == COL_MAX);
  assign row_last  = (cur_row_r == ROW_MAX);
  assign read_ok   = (7'(cmd.row) < 7'(ROWS)) && (8'(cmd.col) < 8'(COLUMNS));
  assign cur_addr  = AW'(cur_row_r) * COLS_A + AW'(cur_col_r);
  assign req_addr  = AW'(cmd.row) * COLS_A + AW'(cmd.col);
  assign pos_col   = (8'(cmd.col) > 8'(COLUMNS - 1)) ? COL_MAX : CW'(cmd.col);
  assign pos_row   = (7'(cmd.row) > 7'(ROWS - 1)) ? ROW_MAX : RW'(cmd.row);
  assign init_busy = init_r;

  ttce_ram #(
    .WIDTH(8),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (take) begin
          case (cmd.op)
            OP_READ:  if (read_ok) state_nxt = BK_READ;
            OP_CLEAR: state_nxt = BK_FILL;
            OP_LF:    if (row_last) state_nxt = BK_SCROLL;
            OP_PUT:   if (row_last && col_last) state_nxt = BK_SCROLL;
            default:  state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_READ:   state_nxt = BK_IDLE;
      BK_FILL:   if (addr_r == LAST_CELL) state_nxt = BK_IDLE;
      BK_SCROLL: if (addr_r == LAST_DST) state_nxt = BK_DRAIN;
      BK_DRAIN:  state_nxt = BK_FILL;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    addr_nxt    = addr_r;
    wr_addr_nxt = wr_addr_r;
    wr_pend_nxt = wr_pend_r;
    pend_nxt    = pend_r;
    init_nxt    = init_r;
    emit        = 1'b0;
    e_redisp    = 1'b0;
    e_bell      = 1'b0;
    e_cell      = 8'h00;
    ram_we      = 1'b0;
    ram_waddr   = cur_addr;
    ram_wdata   = cmd.data;
    ram_re      = 1'b0;
    ram_raddr   = req_addr;
    case (state_r)
      BK_IDLE: begin
        if (take) begin
          case (cmd.op)
            OP_READ: begin
              if (read_ok) begin
                ram_re = 1'b1;
              end else begin
                emit = 1'b1;
              end
            end
            OP_BELL: begin
              emit   = 1'b1;
              e_bell = 1'b1;
            end
            OP_BS: begin
              emit = 1'b1;
              if (cur_col_r != '0) begin
                cur_col_nxt = cur_col_r - 1'b1;
                e_redisp    = 1'b1;
              end
            end
            OP_VT: begin
              emit = 1'b1;
              if (cur_row_r != '0) begin
                cur_row_nxt = cur_row_r - 1'b1;
                e_redisp    = 1'b1;
              end
            end
            OP_FF: begin
              emit = 1'b1;
              if (!col_last) begin
                cur_col_nxt = cur_col_r + 1'b1;
                e_redisp    = 1'b1;
              end
            end
            OP_CR: begin
              emit        = 1'b1;
              e_redisp    = 1'b1;
              cur_col_nxt = '0;
            end
            OP_HOME: begin
              emit        = 1'b1;
              e_redisp    = 1'b1;
              cur_col_nxt = '0;
              cur_row_nxt = '0;
            end
            OP_POS: begin
              emit        = 1'b1;
              e_redisp    = 1'b1;
              cur_col_nxt = pos_col;
              cur_row_nxt = pos_row;
            end
            OP_CLEAR: begin
              cur_col_nxt = '0;
              cur_row_nxt = '0;
              addr_nxt    = '0;
              pend_nxt    = 1'b1;
            end
            OP_LF, OP_PUT: begin
              if (cmd.op == OP_PUT) begin
                ram_we = 1'b1;
              end
              if (cmd.op == OP_PUT && !col_last) begin
                emit        = 1'b1;
                e_redisp    = 1'b1;
                cur_col_nxt = cur_col_r + 1'b1;
              end else if (row_last) begin
                // A line feed, or a character put in the last column, on the bottom row starts a scroll sweep.
                cur_col_nxt = '0;
                addr_nxt    = '0;
                wr_pend_nxt = 1'b0;
                pend_nxt    = 1'b1;
              end else begin
                emit        = 1'b1;
                e_redisp    = 1'b1;
                cur_col_nxt = '0;
                cur_row_nxt = cur_row_r + 1'b1;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        emit   = 1'b1;
        e_cell = ram_rdata;
      end
      BK_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = CH_SPACE;
        addr_nxt  = addr_r + 1'b1;
        if (addr_r == LAST_CELL) begin
          init_nxt = 1'b0;
          pend_nxt = 1'b0;
          if (pend_r) begin
            emit     = 1'b1;
            e_redisp = 1'b1;
          end
        end
      end
      BK_SCROLL: begin
        // Read the cell one row below while writing the previous copy.
        ram_re      = 1'b1;
        ram_raddr   = addr_r + COLS_A;
        ram_we      = wr_pend_r;
        ram_waddr   = wr_addr_r;
        ram_wdata   = ram_rdata;
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = addr_r;
        addr_nxt    = addr_r + 1'b1;
      end
      BK_DRAIN: begin
        ram_we      = 1'b1;
        ram_waddr   = wr_addr_r;
        ram_wdata   = ram_rdata;
        wr_pend_nxt = 1'b0;
        addr_nxt    = BOT_START;
      end
      default: begin
        addr_nxt = addr_r;
      end
    endcase
  end

  assign row_ext = RXW'(cur_row_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FILL;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      addr_r      <= '0;
      wr_pend_r   <= 1'b0;
      pend_r      <= 1'b0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      addr_r      <= addr_nxt;
      wr_pend_r   <= wr_pend_nxt;
      pend_r      <= pend_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= wr_addr_nxt;
    if (emit) begin
      out_redisp_r <= e_redisp;
      out_bell_r   <= e_bell;
      out_cell_r   <= e_cell;
      out_col_r    <= 7'(cur_col_nxt);
      out_row_r    <= row_ext[4:0];
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_redisplay  = out_redisp_r;
  assign out_bell       = out_bell_r;
  assign out_cell_char  = out_cell_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;

endmodule

`default_nettype wire

// ----- rtl/text_terminal_char_engine_core.sv -----
// Top level of the text terminal character engine: decoder, command queue
// and executor. Depends on ttce_pkg, ttce_front, ttce_cmdq and ttce_back.
//
//   Channel   Ports                                    Handshake
//   input     in_req_type in_rx_byte in_read_row/col   in_push, in_full
//   result    out_redisplay out_bell out_cell_char     out_pop, out_empty
//             out_cursor_col out_cursor_row
//
// After reset the screen RAM is swept to spaces, one cell a cycle, and
// in_full stays high until the sweep ends.
// Every word yields one result. Cursor moves, bell, positioning and printable
// characters finish in the idle state unless they start a scroll; a cell read
// also passes through the read state (registered RAM read). Clear and scroll
// sweep the screen cell by cell through the single RAM write port.
// The two-entry command queue keeps the input open for two more words while
// the executor works or while a result waits in the output register; a held
// result stalls the executor, and the input once the queue is full.
`default_nettype none

module text_terminal_char_engine_core
  import ttce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 24
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output      logic       in_full,
  input  wire logic       in_req_type,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic [4:0] in_read_row,
  input  wire logic [6:0] in_read_col,
  output      logic       out_empty,
  input  wire logic       out_pop,
  output      logic       out_redisplay,
  output      logic       out_bell,
  output      logic [7:0] out_cell_char,
  output      logic [6:0] out_cursor_col,
  output      logic [4:0] out_cursor_row
);

  cmd_t front_cmd, q_cmd;
  logic front_push;
  logic q_full, q_empty, q_pop;
  logic init_busy;

  // The decoder stalls while the queue is full or the power-up sweep runs.
  ttce_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .stall      (q_full || init_busy),
    .in_req_type(in_req_type),
    .in_rx_byte (in_rx_byte),
    .in_read_row(in_read_row),
    .in_read_col(in_read_col),
    .in_full    (in_full),
    .cmd_push   (front_push),
    .cmd        (front_cmd)
  );

  ttce_cmdq u_cmdq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (front_push),
    .din  (front_cmd),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_cmd),
    .empty(q_empty)
  );

  // The executor owns the screen, the cursor and the result register.
  ttce_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (!q_empty),
    .cmd           (q_cmd),
    .cmd_pop       (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_redisplay (out_redisplay),
    .out_bell      (out_bell),
    .out_cell_char (out_cell_char),
    .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row),
    .init_busy     (init_busy)
  );

endmodule

`default_nettype wire

// ----- rtl/ttce_checker.sv -----
// Port-level checks for the text terminal character engine, bound to the top.
// Depends on text_terminal_char_engine_core.
`default_nettype none

module ttce_checker #(
  parameter int COLUMNS = 80
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_full,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic       out_redisplay,
  input wire logic       out_bell,
  input wire logic [7:0] out_cell_char,
  input wire logic [6:0] out_cursor_col,
  input wire logic [4:0] out_cursor_row
);

  // The power-up sweep blocks input right after reset.
  a_init_blocks: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_full)
    else $error("input open right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty &&
      $stable({out_redisplay, out_bell, out_cell_char, out_cursor_col, out_cursor_row}))
    else $error("waiting result changed");

  // A nonzero cell comes only from a read, which never redisplays or rings.
  a_cell_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_cell_char != 8'h00 |-> !out_redisplay && !out_bell)
    else $error("cell data on a byte result");

  a_bell_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_bell |-> !out_redisplay)
    else $error("bell with redisplay");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> 8'(out_cursor_col) < 8'(COLUMNS))
    else $error("cursor column beyond screen");

endmodule

bind text_terminal_char_engine_core ttce_checker #(
  .COLUMNS(COLUMNS)
) u_ttce_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_full       (in_full),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_redisplay (out_redisplay),
  .out_bell      (out_bell),
  .out_cell_char (out_cell_char),
  .out_cursor_col(out_cursor_col),
  .out_cursor_row(out_cursor_row)
);

`default_nettype wire
